/* design/block_ring_buffer_manager_core_assert.svh */
// Assertion macros for the ring buffer manager.
`ifndef BLOCK_RING_BUFFER_MANAGER_CORE_ASSERT_SVH
`define BLOCK_RING_BUFFER_MANAGER_CORE_ASSERT_SVH

// Checked on every rising edge once reset is released.
`define BRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define BRB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/brb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package brb_pkg;

  // Ring geometry
  localparam int BLOCKS      = 8;
  localparam int BLOCK_BYTES = 512;
  localparam int IDX_W       = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int FILL_W      = $clog2(BLOCK_BYTES);
  localparam int DEPTH_W     = $clog2(BLOCKS + 1);

  // Field widths
  localparam int LEN_W  = 10;
  localparam int ADDR_W = 32;
  localparam int PEAK_W = 4;
  localparam int PEAK_MAX = 15;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_BASE_ADDRESS = 3'd0;

  // Commands
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PEAK_W-1:0] peak_t;

  // Ring index a + b, wrapped to BLOCKS (b < BLOCKS)
  function automatic idx_t idx_add(input idx_t a, input idx_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(BLOCKS)) begin
      s = s - (IDX_W+1)'(BLOCKS);
    end
    return s[IDX_W-1:0];
  endfunction

  // Byte address of block idx at offset off
  function automatic addr_t blk_addr(input addr_t base, input idx_t idx, input fill_t off);
    return base + ADDR_W'(idx) * ADDR_W'(BLOCK_BYTES) + ADDR_W'(off);
  endfunction

endpackage
`default_nettype wire

/* design/brb_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// Request channel
interface brb_req_if;
  import brb_pkg::*;
  logic valid;
  logic ready;
  logic cmd;
  len_t byte_count;
  modport source (output valid, cmd, byte_count, input ready);
  modport sink   (input valid, cmd, byte_count, output ready);
endinterface

// Result channel
interface brb_res_if;
  import brb_pkg::*;
  logic  valid;
  logic  ready;
  logic  ok;
  addr_t segment_address;
  len_t  segment_length;
  logic  last;
  peak_t deepest_scan;
  modport source (output valid, ok, segment_address, segment_length, last, deepest_scan,
                  input ready);
  modport sink   (input valid, ok, segment_address, segment_length, last, deepest_scan,
                  output ready);
endinterface
`default_nettype wire

/* design/block_ring_buffer_manager_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake        Transaction
// in_      sink       valid / ready    cmd, byte_count
// out_     source     valid / ready    ok, segment_address, segment_length, last, deepest_scan
// cfg_     APB slave  psel / penable   base_address at byte address 0, pready tied high
//
// A get is answered from the idle state: the head block comes from the full-flag register.
// A put reads the fill memory, then S_CALC loads its result into the single output register;
// on a spill S_SPILL loads a second one, and a put with no free block is refused from S_IDLE.
// A new request is taken only when the sequencer is idle and the output register is free.
// rst_n (synchronous) clears all flags, head, peak and base; the fill memory needs no sweep.
// A stalled out_ holds the sequencer in place; in_ stays not ready meanwhile.
module block_ring_buffer_manager_core (
  input  wire                          clk,
  input  wire                          rst_n,
  brb_req_if.sink                      in_,
  brb_res_if.source                    out_,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire [brb_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire [brb_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [brb_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import brb_pkg::*;
  `include "block_ring_buffer_manager_core_assert.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CALC  = 2'd1;
  localparam logic [1:0] S_SPILL = 2'd2;

  // Control state
  logic [1:0]        state_r, state_nxt;
  logic [BLOCKS-1:0] full_r, full_nxt;
  logic [BLOCKS-1:0] fill_vld_r;
  idx_t              head_r, head_nxt;
  peak_t             peak_r, peak_nxt;
  addr_t             base_r;

  // Per-request work registers
  idx_t  f_r, f_nxt;
  len_t  len_r, len_nxt;
  len_t  spill_r, spill_nxt;

  // Fill memory
  fill_t fill_mem [BLOCKS];
  fill_t fill_rd_r;
  logic  mem_re, mem_we;
  idx_t  mem_raddr, mem_waddr;
  fill_t mem_wdata;

  // Output register
  logic  out_valid_r;
  logic  ok_r, last_r;
  addr_t seg_addr_r;
  len_t  seg_len_r;
  peak_t scan_r;
  logic  out_free, out_load, in_acc;
  logic  ld_ok, ld_last;
  addr_t ld_addr;
  len_t  ld_len;
  peak_t ld_scan;

  // Scan and arithmetic
  logic [DEPTH_W-1:0] depth;
  idx_t               scan_idx;
  len_t               len_clamp;
  fill_t              fill_cur;
  logic [LEN_W:0]     fill_sum;
  len_t               rem;
  idx_t               g_idx;
  logic               cfg_wr;

  assign out_free   = !out_valid_r || out_.ready;
  assign in_.ready  = (state_r == S_IDLE) && out_free;
  assign in_acc     = in_.valid && in_.ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_BASE_ADDRESS) ? base_r : '0;

  // First non-full block from the head
  always_comb begin
    depth    = DEPTH_W'(BLOCKS);
    scan_idx = head_r;
    for (int d = BLOCKS - 1; d >= 0; d--) begin
      if (!full_r[idx_add(head_r, IDX_W'(d))]) begin
        depth    = DEPTH_W'(d);
        scan_idx = idx_add(head_r, IDX_W'(d));
      end
    end
  end

  assign len_clamp = (in_.byte_count > LEN_W'(BLOCK_BYTES)) ? LEN_W'(BLOCK_BYTES)
                                                             : in_.byte_count;
  assign fill_cur  = fill_vld_r[f_r] ? fill_rd_r : '0;
  assign fill_sum  = {1'b0, LEN_W'(fill_cur)} + {1'b0, len_r};
  assign rem       = LEN_W'(BLOCK_BYTES) - LEN_W'(fill_cur);
  assign g_idx     = idx_add(f_r, IDX_W'(1));

  // Request sequencer
  always_comb begin
    state_nxt = state_r;
    full_nxt  = full_r;
    head_nxt  = head_r;
    peak_nxt  = peak_r;
    f_nxt     = f_r;
    len_nxt   = len_r;
    spill_nxt = spill_r;
    mem_re    = 1'b0;
    mem_raddr = scan_idx;
    mem_we    = 1'b0;
    mem_waddr = f_r;
    mem_wdata = '0;
    out_load  = 1'b0;
    ld_ok     = 1'b0;
    ld_last   = 1'b1;
    ld_addr   = '0;
    ld_len    = '0;
    ld_scan   = peak_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_.cmd == CMD_GET) begin
            out_load = 1'b1;
            if (full_r[head_r]) begin
              ld_ok            = 1'b1;
              ld_addr          = blk_addr(base_r, head_r, '0);
              ld_len           = LEN_W'(BLOCK_BYTES);
              full_nxt[head_r] = 1'b0;
              head_nxt         = idx_add(head_r, IDX_W'(1));
              mem_we           = 1'b1;
              mem_waddr        = head_r;
            end
          end else begin
            if (32'(depth) > 32'(peak_r)) begin
              peak_nxt = (32'(depth) > PEAK_MAX) ? PEAK_W'(PEAK_MAX) : PEAK_W'(depth);
            end
            ld_scan = peak_nxt;
            if (32'(depth) == BLOCKS) begin
              out_load = 1'b1;
            end else begin
              mem_re    = 1'b1;
              f_nxt     = scan_idx;
              len_nxt   = len_clamp;
              state_nxt = S_CALC;
            end
          end
        end
      end
      S_CALC: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_ok     = 1'b1;
          ld_addr   = blk_addr(base_r, f_r, fill_cur);
          mem_we    = 1'b1;
          mem_waddr = f_r;
          if (fill_sum < (LEN_W+1)'(BLOCK_BYTES)) begin
            ld_len    = len_r;
            mem_wdata = fill_sum[FILL_W-1:0];
            state_nxt = S_IDLE;
          end else begin
            // Tail of this block; the rest goes to the next block
            ld_len        = rem;
            ld_last       = 1'b0;
            full_nxt[f_r] = 1'b1;
            spill_nxt     = len_r - rem;
            state_nxt     = S_SPILL;
          end
        end
      end
      S_SPILL: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (!full_r[g_idx]) begin
            ld_ok     = 1'b1;
            ld_addr   = blk_addr(base_r, g_idx, '0);
            ld_len    = spill_r;
            mem_we    = 1'b1;
            mem_waddr = g_idx;
            mem_wdata = spill_r[FILL_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      full_r      <= '0;
      fill_vld_r  <= '0;
      head_r      <= '0;
      peak_r      <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      full_r  <= full_nxt;
      head_r  <= head_nxt;
      peak_r  <= peak_nxt;
      if (mem_we) begin
        fill_vld_r[mem_waddr] <= 1'b1;
      end
      if (cfg_wr && (cfg_paddr == REG_BASE_ADDRESS)) begin
        base_r <= cfg_pwdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Work and output payload
  always_ff @(posedge clk) begin
    f_r     <= f_nxt;
    len_r   <= len_nxt;
    spill_r <= spill_nxt;
    if (out_load) begin
      ok_r       <= ld_ok;
      last_r     <= ld_last;
      seg_addr_r <= ld_addr;
      seg_len_r  <= ld_len;
      scan_r     <= ld_scan;
    end
  end

  // Fill memory: one read port, one write port; the sequencer never reads and
  // writes in the same cycle, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fill_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      fill_rd_r <= fill_mem[mem_raddr];
    end
  end

  assign out_.valid           = out_valid_r;
  assign out_.ok              = ok_r;
  assign out_.segment_address = seg_addr_r;
  assign out_.segment_length  = seg_len_r;
  assign out_.last            = last_r;
  assign out_.deepest_scan    = scan_r;

  // A non-final result always has its spill result still to come
  `BRB_ASSERT(a_tail_then_spill, (out_valid_r && !last_r) |-> (state_r == S_SPILL),
              "tail segment without pending spill")
  // The peak only grows between resets
  `BRB_ASSERT(a_peak_monotonic, $past(rst_n) |-> (peak_r >= $past(peak_r)),
              "scan peak decreased")
  // A full block at the head always holds fill zero
  `BRB_ASSERT(a_full_fill_zero,
              (full_r[head_r] && fill_vld_r[head_r]) |-> (fill_mem[head_r] == '0),
              "full block with nonzero fill")
  // Memory port never read and written in one cycle
  `BRB_ASSERT_ALWAYS(a_no_rw_overlap, !(mem_re && mem_we), "fill memory read/write overlap")

endmodule
`default_nettype wire

/* dv/block_ring_buffer_manager_core_test.sv */
`timescale 1ns / 1ps
module block_ring_buffer_manager_core_test;
  import brb_pkg::*;

  // One result transaction
  typedef struct packed {
    logic  ok;
    addr_t addr;
    len_t  len;
    logic  last;
    peak_t peak;
  } seg_t;

  // One opening request; typed rows carry their single result
  typedef struct packed {
    logic cmd;
    len_t cnt;
    logic typed;
    seg_t want;
  } row_t;

  localparam int   ROWS         = 23;
  localparam int   DRAIN_CYCLES = 8;
  localparam seg_t NO_SEG       = '0;

  // Base 0x1000 during this part. Rows 5..12 fill the ring, the last of them spills
  // into a full block; the two after find no free block.
  localparam row_t OPENING [ROWS] = '{
    '{CMD_GET, 10'd0,    1'b1, '{1'b0, 32'h0,    10'd0,   1'b1, 4'd0}},
    '{CMD_PUT, 10'd0,    1'b1, '{1'b1, 32'h1000, 10'd0,   1'b1, 4'd0}},
    '{CMD_PUT, 10'd100,  1'b1, '{1'b1, 32'h1000, 10'd100, 1'b1, 4'd0}},
    '{CMD_PUT, 10'd1023, 1'b0, NO_SEG},
    '{CMD_GET, 10'd0,    1'b1, '{1'b1, 32'h1000, 10'd512, 1'b1, 4'd0}},
    '{CMD_PUT, 10'd412,  1'b0, NO_SEG},
    '{CMD_PUT, 10'd512,  1'b0, NO_SEG},
    '{CMD_PUT, 10'd512,  1'b0, NO_SEG},
    '{CMD_PUT, 10'd512,  1'b0, NO_SEG},
    '{CMD_PUT, 10'd512,  1'b0, NO_SEG},
    '{CMD_PUT, 10'd512,  1'b0, NO_SEG},
    '{CMD_PUT, 10'd512,  1'b0, NO_SEG},
    '{CMD_PUT, 10'd512,  1'b0, NO_SEG},
    '{CMD_PUT, 10'd200,  1'b1, '{1'b0, 32'h0,    10'd0,   1'b1, 4'd8}},
    '{CMD_PUT, 10'd1023, 1'b1, '{1'b0, 32'h0,    10'd0,   1'b1, 4'd8}},
    '{CMD_GET, 10'd0,    1'b1, '{1'b1, 32'h1200, 10'd512, 1'b1, 4'd8}},
    '{CMD_PUT, 10'd300,  1'b0, NO_SEG},
    '{CMD_GET, 10'd1023, 1'b1, '{1'b1, 32'h1400, 10'd512, 1'b1, 4'd8}},
    '{CMD_PUT, 10'd511,  1'b0, NO_SEG},
    '{CMD_GET, 10'd0,    1'b1, '{1'b1, 32'h1600, 10'd512, 1'b1, 4'd8}},
    '{CMD_GET, 10'd0,    1'b0, NO_SEG},
    '{CMD_PUT, 10'd513,  1'b0, NO_SEG},
    '{CMD_GET, 10'd0,    1'b0, NO_SEG}
  };

  logic clk;
  logic rst_n;

  brb_req_if req ();
  brb_res_if res ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  wire  [CFG_DW-1:0] cfg_prdata;
  wire               cfg_pready;

  block_ring_buffer_manager_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_         (req),
    .out_        (res),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Ring state as the block should hold it
  bit          full_q [BLOCKS];
  int unsigned fill_q [BLOCKS];
  int unsigned head_idx;
  int unsigned peak_q;
  addr_t       base_reg;

  seg_t planned[$];
  seg_t segments_due[$];

  int unsigned errors;
  int unsigned puts_sent;
  int unsigned gets_sent;
  int unsigned segments_seen;
  int unsigned refusals_seen;
  int unsigned sink_stall_pct;
  int unsigned stall_left;

  always #5 clk = ~clk;

  function automatic addr_t block_base(input int unsigned k);
    return base_reg + addr_t'(k * BLOCK_BYTES);
  endfunction

  function automatic seg_t make_segment(input logic ok, input addr_t a, input int unsigned len,
                                        input logic last);
    seg_t s;
    s.ok   = ok;
    s.addr = a;
    s.len  = len_t'(len);
    s.last = last;
    s.peak = peak_t'(peak_q);
    return s;
  endfunction

  // Segments one request produces; updates the ring state
  function automatic void plan_request(input logic cmd, input len_t cnt);
    int unsigned h, d, f, g, n, rem;
    planned.delete();
    h = head_idx;
    if (cmd == CMD_GET) begin
      if (full_q[h]) begin
        full_q[h] = 1'b0;
        fill_q[h] = 0;
        head_idx  = (h + 1) % BLOCKS;
        planned.push_back(make_segment(1'b1, block_base(h), BLOCK_BYTES, 1'b1));
      end else begin
        planned.push_back(make_segment(1'b0, '0, 0, 1'b1));
      end
      return;
    end
    n = (cnt > BLOCK_BYTES) ? BLOCK_BYTES : cnt;
    // skip full blocks from the head
    d = 0;
    while (d < BLOCKS && full_q[(h + d) % BLOCKS]) d++;
    if (d > peak_q) peak_q = (d > PEAK_MAX) ? PEAK_MAX : d;
    if (d == BLOCKS) begin
      planned.push_back(make_segment(1'b0, '0, 0, 1'b1));
      return;
    end
    f = (h + d) % BLOCKS;
    if (fill_q[f] + n < BLOCK_BYTES) begin
      planned.push_back(make_segment(1'b1, block_base(f) + addr_t'(fill_q[f]), n, 1'b1));
      fill_q[f] += n;
      return;
    end
    // reaches block end: tail segment, then spill into next block
    rem = BLOCK_BYTES - fill_q[f];
    planned.push_back(make_segment(1'b1, block_base(f) + addr_t'(fill_q[f]), rem, 1'b0));
    fill_q[f] = 0;
    full_q[f] = 1'b1;
    g = (f + 1) % BLOCKS;
    if (full_q[g]) begin
      planned.push_back(make_segment(1'b0, '0, 0, 1'b1));
    end else begin
      fill_q[g] = n - rem;
      planned.push_back(make_segment(1'b1, block_base(g), n - rem, 1'b1));
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Drive one request and wait for its transaction; valid stays high afterwards
  task automatic send_request(input logic cmd, input len_t cnt, input logic typed,
                              input seg_t want);
    @(negedge clk);
    req.valid      <= 1'b1;
    req.cmd        <= cmd;
    req.byte_count <= cnt;
    do @(posedge clk); while (!req.ready);
    plan_request(cmd, cnt);
    if (typed) begin
      segments_due.push_back(want);
    end else begin
      foreach (planned[k]) segments_due.push_back(planned[k]);
    end
    if (cmd == CMD_GET) gets_sent++;
    else puts_sent++;
  endtask

  task automatic pause_sender(input int unsigned n);
    @(negedge clk);
    req.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Hold off until every result has come, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    req.valid <= 1'b0;
    while (segments_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write base_address, then read it back
  task automatic cfg_write(input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] got;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_BASE_ADDRESS;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    base_reg = value;
    check_field("base_address readback", value, got);
  endtask

  // Random traffic in chunks of 50 that lean toward puts or toward gets
  task automatic run_phase(input int unsigned items, input int unsigned idle_pct,
                           input bit pressure);
    int unsigned put_pct, burst_pct;
    logic        cmd;
    len_t        cnt;
    put_pct   = 50;
    burst_pct = 0;
    for (int i = 0; i < items; i++) begin
      if (i % 50 == 0) begin
        put_pct        = $urandom_range(35, 75);
        burst_pct      = (idle_pct != 0 && $urandom_range(0, 3) != 0) ? idle_pct : 0;
        sink_stall_pct = burst_pct;
      end
      cmd = ($urandom_range(0, 99) < put_pct) ? CMD_PUT : CMD_GET;
      case ($urandom_range(0, 9))
        0:       cnt = '0;
        1:       cnt = len_t'(BLOCK_BYTES);
        2:       cnt = len_t'(BLOCK_BYTES - 1);
        3:       cnt = len_t'($urandom_range(BLOCK_BYTES + 1, 1023));
        4:       cnt = len_t'($urandom_range(1, 15));
        default: cnt = len_t'($urandom_range(0, BLOCK_BYTES));
      endcase
      send_request(cmd, cnt, 1'b0, NO_SEG);
      if (pressure && i % 100 == 99) begin
        wait_idle();
      end else if ($urandom_range(0, 99) < burst_pct) begin
        pause_sender($urandom_range(1, 11));
      end
    end
  endtask

  // Result side backpressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      res.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      res.ready <= 1'b0;
      stall_left = $urandom_range(0, 10);
    end else begin
      res.ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest pending segment
  always @(posedge clk) begin : watch_results
    seg_t want;
    if (rst_n && res.valid && res.ready) begin
      segments_seen++;
      if (!res.ok) refusals_seen++;
      if (segments_due.size() == 0) begin
        errors++;
        $display("%0t: result with none pending, got ok=%0b addr=%0h len=%0d last=%0b",
                 $time, res.ok, res.segment_address, res.segment_length, res.last);
      end else begin
        want = segments_due.pop_front();
        check_field("ok", want.ok, res.ok);
        check_field("segment_address", want.addr, res.segment_address);
        check_field("segment_length", want.len, res.segment_length);
        check_field("last", want.last, res.last);
        check_field("deepest_scan", want.peak, res.deepest_scan);
      end
    end
  end

  initial begin
    #5000000;
    $display("block_ring_buffer_manager_core: mismatch");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    req.valid      = 1'b0;
    req.cmd        = CMD_PUT;
    req.byte_count = '0;
    res.ready      = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    foreach (full_q[k]) begin
      full_q[k] = 1'b0;
      fill_q[k] = 0;
    end
    head_idx       = 0;
    peak_q         = 0;
    base_reg       = '0;
    errors         = 0;
    puts_sent      = 0;
    gets_sent      = 0;
    segments_seen  = 0;
    refusals_seen  = 0;
    sink_stall_pct = 25;
    stall_left     = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows
    cfg_write(32'h0000_1000);
    for (int r = 0; r < ROWS; r++) begin
      send_request(OPENING[r].cmd, OPENING[r].cnt, OPENING[r].typed, OPENING[r].want);
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 11));
    end

    // random phases, base changed only while idle
    wait_idle();
    cfg_write(32'hFFFF_FFFF);
    run_phase(500, 30, 1'b0);
    wait_idle();
    cfg_write(32'h0000_0000);
    run_phase(500, 20, 1'b1);
    wait_idle();
    cfg_write($urandom);
    run_phase(500, 40, 1'b0);
    wait_idle();
    cfg_write(32'hFFFF_FE00);
    run_phase(400, 0, 1'b0);
    wait_idle();

    $display("Ran %0d puts and %0d gets across five base addresses, wrap-around included.",
             puts_sent, gets_sent);
    $display("Checked %0d result segments, %0d of them refusals; %0d errors.",
             segments_seen, refusals_seen, errors);
    if (errors == 0 && segments_due.size() == 0) begin
      $display("block_ring_buffer_manager_core: match");
    end else begin
      $display("block_ring_buffer_manager_core: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/brb_pkg.sv
design/brb_if.sv
design/block_ring_buffer_manager_core.sv
dv/block_ring_buffer_manager_core_test.sv
